FILE: src/sfh_pkg.sv
// Shared types and constants for the scope slot FNV-1a hash block.
`timescale 1ns / 1ps

package sfh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  SEPARATOR = 8'h7C;

  localparam logic [7:0]  SLOT_COUNT_RESET = 8'd255;
  localparam logic [7:0]  SLOT_BASE_RESET  = 8'd0;

  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int PADDR_W = 3;

  localparam logic [0:0] REG_SLOT_COUNT = 1'b0;
  localparam logic [0:0] REG_SLOT_BASE  = 1'b1;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic fold;
    logic sep;
    logic finish;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic div_last;
  } status_t;

endpackage

FILE: src/scope_slot_fnv1a_hash_top.sv
// Top level: APB register file, controller and datapath of the slot hash.
`timescale 1ns / 1ps

// Folds string bytes and end marks into a 32-bit FNV-1a hash, one request per
// cycle while idle; zero bytes are dropped. The third end mark closes the
// triple: the hash is reduced modulo slot_count by a one-bit-per-cycle
// shift-subtract unit, then slot_base is added and the result is loaded into
// the output register once no previous result still waits there. From the
// closing request until that load, no new request is taken. A slot_count of
// zero reduces modulo 256. Once loaded, a result may wait to be taken while
// new requests enter.

module scope_slot_fnv1a_hash_top import sfh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [7:0]         char_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         slot_num
);

  logic [7:0] slot_count;
  logic [7:0] slot_base;
  cmd_t       cmd;
  status_t    status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RESET;
      slot_base  <= SLOT_BASE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SLOT_COUNT: slot_count <= pwdata[7:0];
        REG_SLOT_BASE:  slot_base  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOT_COUNT: prdata = {24'd0, slot_count};
      REG_SLOT_BASE:  prdata = {24'd0, slot_base};
      default:        prdata = 32'd0;
    endcase
  end

  sfh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfh_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .char_byte  (char_byte),
    .slot_count (slot_count),
    .slot_base  (slot_base),
    .cmd        (cmd),
    .status     (status),
    .slot_num   (slot_num)
  );

  a_finish_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (!in_ready && cmd.div_step))
    else $error("input taken while remainder unit busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

endmodule

FILE: src/sfh_dp.sv
// Datapath: running hash, shift-subtract remainder unit and output register.
`timescale 1ns / 1ps

module sfh_dp import sfh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_byte,
  input  logic [7:0] slot_count,
  input  logic [7:0] slot_base,
  input  cmd_t       cmd,
  output status_t    status,
  output logic [7:0] slot_num
);

  logic [31:0]       hash;
  logic [31:0]       dvd;
  logic [7:0]        rem;
  logic [7:0]        cnt;
  logic [7:0]        low;
  logic [STEP_W-1:0] step;

  logic [7:0]  fold_in;
  logic [31:0] folded;
  logic [8:0]  trial;
  logic [8:0]  diff;
  logic [7:0]  rem_next;
  logic [7:0]  reduced;

  always_comb begin
    fold_in  = cmd.sep ? SEPARATOR : char_byte;
    folded   = (hash ^ {24'd0, fold_in}) * FNV_PRIME;
    trial    = {rem, dvd[31]};
    diff     = trial - {1'b0, cnt};
    rem_next = (trial >= {1'b0, cnt}) ? diff[7:0] : trial[7:0];
    reduced  = (cnt == 8'd0) ? low : rem;
    status.byte_zero = (char_byte == 8'd0);
    status.div_last  = (step == STEP_W'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= FNV_BASIS;
    end else if (cmd.finish) begin
      hash <= FNV_BASIS;
      dvd  <= folded;
      low  <= folded[7:0];
      cnt  <= slot_count;
      rem  <= 8'd0;
      step <= '0;
    end else if (cmd.fold) begin
      hash <= folded;
    end
    if (cmd.div_step) begin
      dvd  <= {dvd[30:0], 1'b0};
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
    if (cmd.load_out) begin
      slot_num <= reduced + slot_base;
    end
  end

endmodule

FILE: src/sfh_ctrl.sv
// Controller: request sequencing, string count and output valid flag.
`timescale 1ns / 1ps

module sfh_ctrl import sfh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    func,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state, state_next;
  logic [1:0] strings_done, strings_done_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      strings_done <= 2'd0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      strings_done <= strings_done_next;
      out_valid    <= out_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    strings_done_next = strings_done;
    cmd               = '0;
    in_ready          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_END) begin
            cmd.fold = 1'b1;
            cmd.sep  = 1'b1;
            if (strings_done == 2'd2) begin
              cmd.finish        = 1'b1;
              strings_done_next = 2'd0;
              state_next        = ST_DIV;
            end else begin
              strings_done_next = strings_done + 2'd1;
            end
          end else if (!status.byte_zero) begin
            cmd.fold = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
